>>> src/first_fit_heap_allocator_top_macros.svh
// Assertion macros for the first-fit heap allocator checker.
// Uses the clk_i and rst_ni names of the module that expands them.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FFA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ffa assertion failed");

// Next-cycle implication, disabled during reset
`define FFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ffa assertion failed");

// Implication that is also checked while reset is applied
`define FFA_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) (ante) |-> (cons)) \
    else $error("ffa assertion failed");

`endif

>>> src/ffa_pkg.sv
// Package for the first-fit heap allocator: constants, codes and types.
// No dependencies; used by the top level and the checker.
`default_nettype none

package ffa_pkg;

  localparam int unsigned HEAP_BYTES_DEF = 65536;
  localparam int unsigned GRANULE_BYTES  = 16;
  localparam int unsigned GRAN_SHIFT     = 4;
  localparam int unsigned REQ_W          = 16;
  // granules needed for the largest request plus its header
  localparam int unsigned NEED_W         = 13;

  // commands (tuser on the input)
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes (tuser on the output)
  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FREED   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_CHK,
    S_A_WR,
    S_F_WALK,
    S_F_LINK,
    S_M_LO,
    S_M_CHK,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] offset;
  } result_t;

endpackage

`default_nettype wire

>>> src/first_fit_heap_allocator_top.sv
// First-fit heap allocator with an address-ordered free list and coalescing.
// Depends on ffa_pkg; block sizes and links live in two synchronous RAMs.
//
//  channel  dir  handshake                  tdata                  tuser
//  s_axis   in   s_axis_tvalid/tready       request_bytes,offset   command
//  m_axis   out  m_axis_tvalid/tready       data_offset            status
//
// Allocate: read the head, check each free-list entry passed over, write
// back, then load the output register. Free: walk the list, link, check each
// merge, then load the output register; a new list head skips walk and link.
// The list walk, one RAM read per entry, sets the rate.
// Reset clears the control state and the list head; RAM entry 0 reads as
// the whole heap until written, no clearing pass. A new item is taken while
// a result still waits on m_axis; the next result then waits for it.
`default_nettype none

module first_fit_heap_allocator_top #(
  parameter int unsigned HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] request_bytes, [31:16] free_offset
  input  wire logic [31:0] s_axis_tdata,
  // [0] command
  input  wire logic [0:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] data_offset
  output logic [15:0]      m_axis_tdata,
  // [1:0] status
  output logic [1:0]       m_axis_tuser
);

  localparam int unsigned HG    = HEAP_BYTES / ffa_pkg::GRANULE_BYTES;
  localparam int unsigned AW    = $clog2(HG);
  localparam int unsigned LW    = $clog2(HG + 1);
  localparam int unsigned CW    = ((LW > ffa_pkg::NEED_W) ? LW : ffa_pkg::NEED_W) + 1;
  localparam int unsigned SW    = $clog2(HG + 2);
  localparam logic [LW-1:0] NIL = LW'(HG);
  localparam logic [SW-1:0] WALK_LIMIT = SW'(HG + 1);

  function automatic logic [LW-1:0] norm_link(input logic [LW-1:0] v);
    return (v < NIL) ? v : NIL;
  endfunction

  // storage
  logic [LW-1:0] blk_mem [HG];
  logic [LW-1:0] nxt_mem [HG];

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] blk_rd_q, nxt_rd_q;
  logic          blk_dflt_q, nxt_dflt_q;
  logic [LW-1:0] blk_rd, nxt_rd;

  logic          blk_we, nxt_we;
  logic [AW-1:0] blk_wa, nxt_wa;
  logic [LW-1:0] blk_wd, nxt_wd;
  logic [1:0]    v0_q, v0_d;

  ffa_pkg::state_e  state_q, state_d;
  logic [ffa_pkg::NEED_W-1:0] need_q, need_d;
  logic [LW-1:0]    g_q, g_d, cur_q, cur_d, prev_q, prev_d, succ_q, succ_d;
  logic [LW-1:0]    head_q, head_d, mlo_q, mlo_d, mhi_q, mhi_d, szlo_q, szlo_d;
  logic [SW-1:0]    steps_q, steps_d;
  logic             split_q, split_d, merge2_q, merge2_d;
  ffa_pkg::result_t res_q, res_d, out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // RAM write and registered read
  always_ff @(posedge clk_i) begin
    if (blk_we) begin
      blk_mem[blk_wa] <= blk_wd;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (rd_en) begin
      blk_rd_q <= blk_mem[rd_addr];
      nxt_rd_q <= nxt_mem[rd_addr];
    end
  end

  // entry 0 holds its reset value until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q       <= 2'b00;
      blk_dflt_q <= 1'b1;
      nxt_dflt_q <= 1'b1;
    end else begin
      v0_q <= v0_d;
      if (rd_en) begin
        blk_dflt_q <= (rd_addr == '0) && !v0_q[0];
        nxt_dflt_q <= (rd_addr == '0) && !v0_q[1];
      end
    end
  end

  always_comb begin
    v0_d = v0_q;
    if (blk_we && (blk_wa == '0)) v0_d[0] = 1'b1;
    if (nxt_we && (nxt_wa == '0)) v0_d[1] = 1'b1;
  end

  // reset values: whole heap and the null link are both HG
  assign blk_rd = blk_dflt_q ? NIL : blk_rd_q;
  assign nxt_rd = nxt_dflt_q ? NIL : nxt_rd_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffa_pkg::S_IDLE;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    need_q   <= need_d;
    g_q      <= g_d;
    cur_q    <= cur_d;
    prev_q   <= prev_d;
    succ_q   <= succ_d;
    mlo_q    <= mlo_d;
    mhi_q    <= mhi_d;
    szlo_q   <= szlo_d;
    steps_q  <= steps_d;
    split_q  <= split_d;
    merge2_q <= merge2_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  // sequencer
  always_comb begin
    logic [15:0]   req, off;
    logic [16:0]   req_sum;
    logic [11:0]   gg, g12;
    logic [LW-1:0] hn, nx;
    logic [SW-1:0] steps_inc;
    logic [31:0]   off32;

    req       = s_axis_tdata[15:0];
    off       = s_axis_tdata[31:16];
    req_sum   = {1'b0, req} + 17'd15;
    gg        = off[15:ffa_pkg::GRAN_SHIFT];
    g12       = gg - 12'd1;
    hn        = norm_link(head_q);
    nx        = norm_link(nxt_rd);
    steps_inc = steps_q + SW'(1);
    off32     = (32'(cur_q) + 32'd1) << ffa_pkg::GRAN_SHIFT;

    state_d  = state_q;
    head_d   = head_q;
    need_d   = need_q;
    g_d      = g_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    succ_d   = succ_q;
    mlo_d    = mlo_q;
    mhi_d    = mhi_q;
    szlo_d   = szlo_q;
    steps_d  = steps_q;
    split_d  = split_q;
    merge2_d = merge2_q;
    res_d    = res_q;
    out_d    = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    rd_en   = 1'b0;
    rd_addr = '0;
    blk_we  = 1'b0;
    blk_wa  = '0;
    blk_wd  = '0;
    nxt_we  = 1'b0;
    nxt_wa  = '0;
    nxt_wd  = '0;

    s_axis_tready = (state_q == ffa_pkg::S_IDLE);

    case (state_q)
      ffa_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          res_d.offset = '0;
          if (s_axis_tuser[0] == ffa_pkg::CMD_ALLOC) begin
            need_d  = ffa_pkg::NEED_W'(req_sum[16:ffa_pkg::GRAN_SHIFT]) +
                      ffa_pkg::NEED_W'(1);
            prev_d  = NIL;
            steps_d = '0;
            if (hn == NIL) begin
              res_d.status = ffa_pkg::ST_NOFIT;
              state_d = ffa_pkg::S_DONE;
            end else begin
              cur_d   = hn;
              rd_en   = 1'b1;
              rd_addr = AW'(hn);
              state_d = ffa_pkg::S_A_CHK;
            end
          end else if ((gg == '0) || (CW'(g12) >= CW'(HG))) begin
            res_d.status = ffa_pkg::ST_IGNORED;
            state_d = ffa_pkg::S_DONE;
          end else begin
            g_d = LW'(g12);
            if ((hn == NIL) || (CW'(g12) < CW'(hn))) begin
              // new list head
              nxt_we  = 1'b1;
              nxt_wa  = AW'(g12);
              nxt_wd  = hn;
              head_d  = LW'(g12);
              res_d.status = ffa_pkg::ST_FREED;
              if (hn == NIL) begin
                state_d = ffa_pkg::S_DONE;
              end else begin
                mlo_d    = LW'(g12);
                mhi_d    = hn;
                merge2_d = 1'b0;
                rd_en    = 1'b1;
                rd_addr  = AW'(g12);
                state_d  = ffa_pkg::S_M_LO;
              end
            end else if (CW'(g12) == CW'(hn)) begin
              res_d.status = ffa_pkg::ST_IGNORED;
              state_d = ffa_pkg::S_DONE;
            end else begin
              prev_d  = hn;
              steps_d = '0;
              rd_en   = 1'b1;
              rd_addr = AW'(hn);
              state_d = ffa_pkg::S_F_WALK;
            end
          end
        end
      end

      // first-fit check of the entry just read
      ffa_pkg::S_A_CHK: begin
        if (CW'(blk_rd) >= CW'(need_q)) begin
          res_d.status = ffa_pkg::ST_ALLOC;
          res_d.offset = off32[15:0];
          if ((CW'(blk_rd) == CW'(need_q)) || (CW'(cur_q) + CW'(need_q) >= CW'(HG))) begin
            succ_d  = nx;
            split_d = 1'b0;
          end else begin
            blk_we  = 1'b1;
            blk_wa  = AW'(CW'(cur_q) + CW'(need_q));
            blk_wd  = LW'(CW'(blk_rd) - CW'(need_q));
            nxt_we  = 1'b1;
            nxt_wa  = blk_wa;
            nxt_wd  = nx;
            succ_d  = LW'(CW'(cur_q) + CW'(need_q));
            split_d = 1'b1;
          end
          state_d = ffa_pkg::S_A_WR;
        end else begin
          prev_d  = cur_q;
          steps_d = steps_inc;
          if ((nx == NIL) || (steps_inc >= WALK_LIMIT)) begin
            res_d.status = ffa_pkg::ST_NOFIT;
            state_d = ffa_pkg::S_DONE;
          end else begin
            cur_d   = nx;
            rd_en   = 1'b1;
            rd_addr = AW'(nx);
          end
        end
      end

      // shrink the taken block and relink its predecessor or the list head
      ffa_pkg::S_A_WR: begin
        if (split_q) begin
          blk_we = 1'b1;
          blk_wa = AW'(cur_q);
          blk_wd = LW'(need_q);
        end
        if (prev_q == NIL) begin
          head_d = succ_q;
        end else begin
          nxt_we = 1'b1;
          nxt_wa = AW'(prev_q);
          nxt_wd = succ_q;
        end
        state_d = ffa_pkg::S_DONE;
      end

      // find the insertion point in address order
      ffa_pkg::S_F_WALK: begin
        if ((steps_q >= WALK_LIMIT) || (nx == NIL) || (nx >= g_q)) begin
          if (nx == g_q) begin
            res_d.status = ffa_pkg::ST_IGNORED;
            state_d = ffa_pkg::S_DONE;
          end else begin
            nxt_we  = 1'b1;
            nxt_wa  = AW'(g_q);
            nxt_wd  = nx;
            cur_d   = nx;
            state_d = ffa_pkg::S_F_LINK;
          end
        end else begin
          prev_d  = nx;
          steps_d = steps_inc;
          rd_en   = 1'b1;
          rd_addr = AW'(nx);
        end
      end

      ffa_pkg::S_F_LINK: begin
        nxt_we = 1'b1;
        nxt_wa = AW'(prev_q);
        nxt_wd = g_q;
        res_d.status = ffa_pkg::ST_FREED;
        rd_en  = 1'b1;
        if (cur_q == NIL) begin
          mlo_d    = prev_q;
          mhi_d    = g_q;
          merge2_d = 1'b0;
          rd_addr  = AW'(prev_q);
        end else begin
          mlo_d    = g_q;
          mhi_d    = cur_q;
          merge2_d = 1'b1;
          rd_addr  = AW'(g_q);
        end
        state_d = ffa_pkg::S_M_LO;
      end

      // merge check: lower block size in, read upper block
      ffa_pkg::S_M_LO: begin
        szlo_d  = blk_rd;
        rd_en   = 1'b1;
        rd_addr = AW'(mhi_q);
        state_d = ffa_pkg::S_M_CHK;
      end

      ffa_pkg::S_M_CHK: begin
        if (CW'(mlo_q) + CW'(szlo_q) == CW'(mhi_q)) begin
          blk_we = 1'b1;
          blk_wa = AW'(mlo_q);
          blk_wd = szlo_q + blk_rd;
          nxt_we = 1'b1;
          nxt_wa = AW'(mlo_q);
          nxt_wd = nx;
        end
        if (merge2_q) begin
          mlo_d    = prev_q;
          mhi_d    = g_q;
          merge2_d = 1'b0;
          rd_en    = 1'b1;
          rd_addr  = AW'(prev_q);
          state_d  = ffa_pkg::S_M_LO;
        end else begin
          state_d = ffa_pkg::S_DONE;
        end
      end

      // hand the result to the output register
      ffa_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ffa_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ffa_pkg::S_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.offset;
  assign m_axis_tuser  = out_q.status;

endmodule

`default_nettype wire

>>> src/ffa_checker.sv
// Port-level checker for the first-fit heap allocator, bound to the top level.
// Depends on ffa_pkg and first_fit_heap_allocator_top_macros.svh.
`default_nettype none
`include "first_fit_heap_allocator_top_macros.svh"

module ffa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // a stalled result holds
  `FFA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // only an allocation carries an offset
  `FFA_ASSERT_IMPL(a_zero_off, m_axis_tvalid && (m_axis_tuser != ffa_pkg::ST_ALLOC),
                   m_axis_tdata == 16'd0)

  // data offsets are granule aligned
  `FFA_ASSERT_IMPL(a_aligned, m_axis_tvalid, m_axis_tdata[3:0] == 4'd0)

  // no result during reset
  `FFA_ASSERT_ALWAYS(a_rst_quiet, !rst_ni, !m_axis_tvalid)

endmodule

bind first_fit_heap_allocator_top ffa_checker u_ffa_checker (.*);

`default_nettype wire
